// File: src/lcdnws_pkg.sv
// ----------------------------------------------------------------------------
// lcdnws_pkg
// Shared types, constants and the power-up segment table for the 4-bit
// character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdnws_pkg;

    localparam int DATA_W    = 8;
    localparam int NIB_W     = 4;
    localparam int HOLD_W    = 16;
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int SEG_W     = 4;
    localparam int PH_W      = 3;

    localparam logic [HOLD_W-1:0] STD_DELAY_RST   = 16'd50;
    localparam logic [HOLD_W-1:0] CLEAR_DELAY_RST = 16'd1700;
    localparam logic [HOLD_W-1:0] WAIT_POWER_US   = 16'd15000;
    localparam logic [HOLD_W-1:0] WAIT_SECOND_US  = 16'd4500;
    localparam logic [HOLD_W-1:0] WAIT_THIRD_US   = 16'd100;

    // Power-up command bytes
    localparam logic [DATA_W-1:0] INIT_NIB_3     = 8'h03;
    localparam logic [DATA_W-1:0] CMD_FOUR_BIT   = 8'h32;
    localparam logic [DATA_W-1:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [DATA_W-1:0] CMD_DISP_OFF   = 8'h08;
    localparam logic [DATA_W-1:0] CMD_CLEAR      = 8'h01;
    localparam logic [DATA_W-1:0] CMD_ENTRY_MODE = 8'h06;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_INIT  = 1'b1
    } op_t;

    typedef enum logic {
        CFG_STD_DELAY   = 1'b0,
        CFG_CLEAR_DELAY = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        SEG_WAIT,
        SEG_NIBBLE,
        SEG_BYTE
    } seg_kind_t;

    typedef enum logic [2:0] {
        HOLD_ITEM,
        HOLD_STD,
        HOLD_CLEAR,
        HOLD_POWER,
        HOLD_SECOND,
        HOLD_THIRD
    } hold_sel_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // One segment of a run: a wait, a single nibble or a full byte
    typedef struct packed {
        seg_kind_t           kind;
        logic                use_item;
        logic [DATA_W-1:0]   value;
        hold_sel_t           hold_sel;
        logic                final_seg;
    } seg_t;

    // Controller to datapath
    typedef struct packed {
        logic                capture;
        logic                emit;
        logic                enable;
        logic                load;
        logic                nib_hi;
        logic                use_item;
        logic [DATA_W-1:0]   value;
        hold_sel_t           hold_sel;
        logic                last;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Power-up sequence, one entry per segment
    function automatic seg_t init_seg(input logic [SEG_W-1:0] idx);
        seg_t s;
        s = '{kind: SEG_WAIT, use_item: 1'b0, value: '0, hold_sel: HOLD_STD,
              final_seg: 1'b0};
        case (idx)
            4'd0: begin s.kind = SEG_WAIT;   s.hold_sel = HOLD_POWER; end
            4'd1: begin s.kind = SEG_NIBBLE; s.value = INIT_NIB_3; end
            4'd2: begin s.kind = SEG_WAIT;   s.hold_sel = HOLD_SECOND; end
            4'd3: begin s.kind = SEG_NIBBLE; s.value = INIT_NIB_3; end
            4'd4: begin s.kind = SEG_WAIT;   s.hold_sel = HOLD_THIRD; end
            4'd5: begin s.kind = SEG_BYTE;   s.value = CMD_FOUR_BIT; end
            4'd6: begin s.kind = SEG_BYTE;   s.value = CMD_FUNC_SET; end
            4'd7: begin s.kind = SEG_BYTE;   s.value = CMD_DISP_OFF; end
            4'd8: begin
                s.kind     = SEG_BYTE;
                s.value    = CMD_CLEAR;
                s.hold_sel = HOLD_CLEAR;
            end
            4'd9: begin
                s.kind      = SEG_BYTE;
                s.value     = CMD_ENTRY_MODE;
                s.final_seg = 1'b1;
            end
            default: begin
                s.kind      = SEG_WAIT;
                s.final_seg = 1'b1;
            end
        endcase
        return s;
    endfunction

endpackage

// File: src/lcdnws_ctrl.sv
// ----------------------------------------------------------------------------
// lcdnws_ctrl
// Sequencer: walks the segments of a write or power-up run and issues one
// phase command per cycle whenever the output register can take it.
// ----------------------------------------------------------------------------
module lcdnws_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  lcdnws_pkg::op_t       in_op,
    input  lcdnws_pkg::dp_status_t status,
    output lcdnws_pkg::dp_cmd_t   cmd
);
    import lcdnws_pkg::*;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [SEG_W-1:0]   seg_reg, seg_next;
    logic [PH_W-1:0]    ph_reg, ph_next;

    seg_t               seg;
    logic [PH_W-1:0]    ph_end;
    logic               ph_done;
    logic               strobe;

    // Current segment descriptor
    always_comb begin
        if (op_reg == OP_INIT) begin
            seg = init_seg(seg_reg);
        end else begin
            seg = '{kind: SEG_BYTE, use_item: 1'b1, value: '0,
                    hold_sel: HOLD_ITEM, final_seg: 1'b1};
        end
        case (seg.kind)
            SEG_WAIT:   ph_end = 3'd0;
            SEG_NIBBLE: ph_end = 3'd2;
            SEG_BYTE:   ph_end = 3'd5;
            default:    ph_end = 3'd0;
        endcase
        ph_done = (ph_reg == ph_end);
        // enable high phases also latch the new pins
        strobe  = (seg.kind == SEG_NIBBLE && ph_reg == 3'd1) ||
                  (seg.kind == SEG_BYTE && (ph_reg == 3'd1 || ph_reg == 3'd4));
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_WRITE;
            seg_reg   <= '0;
            ph_reg    <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            seg_reg   <= seg_next;
            ph_reg    <= ph_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        seg_next     = seg_reg;
        ph_next      = ph_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.enable   = strobe;
        cmd.load     = strobe;
        cmd.nib_hi   = (seg.kind == SEG_BYTE) && (ph_reg < 3'd3);
        cmd.use_item = seg.use_item;
        cmd.value    = seg.value;
        cmd.hold_sel = seg.hold_sel;
        cmd.last     = seg.final_seg && ph_done;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = 1'b0;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    op_next     = in_op;
                    seg_next    = '0;
                    ph_next     = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (!ph_done) begin
                        ph_next = ph_reg + 3'd1;
                    end else if (seg.final_seg) begin
                        state_next = ST_IDLE;
                    end else begin
                        seg_next = seg_reg + 4'd1;
                        ph_next  = '0;
                    end
                end else begin
                    cmd.load = 1'b0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/lcdnws_dp.sv
// ----------------------------------------------------------------------------
// lcdnws_dp
// Datapath: delay registers, item latch, driven pin state and the output
// register toward the result channel.
// ----------------------------------------------------------------------------
module lcdnws_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  lcdnws_pkg::cfg_index_t                cfg_index,
    input  logic [lcdnws_pkg::HOLD_W-1:0]         cfg_data,
    input  logic [lcdnws_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [lcdnws_pkg::S_TUSER_W-1:0]      s_tuser,
    input  lcdnws_pkg::dp_cmd_t                   cmd,
    output lcdnws_pkg::dp_status_t                status,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lcdnws_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tlast
);
    import lcdnws_pkg::*;

    logic [HOLD_W-1:0] std_delay_reg, clear_delay_reg;
    logic [DATA_W-1:0] item_byte_reg;
    logic              item_rs_reg;
    logic [HOLD_W-1:0] item_hold_reg;
    logic              held_rs_reg;
    logic [NIB_W-1:0]  held_nibble_reg;
    logic              m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic              m_last_reg;

    logic [DATA_W-1:0] src_byte;
    logic [NIB_W-1:0]  new_nib, out_nib;
    logic              new_rs, out_rs;
    logic [HOLD_W-1:0] hold;

    assign status.out_free = !m_valid_reg || m_tready;

    // Phase pin levels and hold time
    always_comb begin
        src_byte = cmd.use_item ? item_byte_reg : cmd.value;
        new_nib  = cmd.nib_hi ? src_byte[7:4] : src_byte[3:0];
        new_rs   = cmd.use_item ? item_rs_reg : 1'b0;
        out_nib  = cmd.load ? new_nib : held_nibble_reg;
        out_rs   = cmd.load ? new_rs : held_rs_reg;
        case (cmd.hold_sel)
            HOLD_ITEM:   hold = item_hold_reg;
            HOLD_STD:    hold = std_delay_reg;
            HOLD_CLEAR:  hold = clear_delay_reg;
            HOLD_POWER:  hold = WAIT_POWER_US;
            HOLD_SECOND: hold = WAIT_SECOND_US;
            HOLD_THIRD:  hold = WAIT_THIRD_US;
            default:     hold = std_delay_reg;
        endcase
    end

    // Config and pin state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            std_delay_reg   <= STD_DELAY_RST;
            clear_delay_reg <= CLEAR_DELAY_RST;
            held_rs_reg     <= 1'b0;
            held_nibble_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_STD_DELAY:   std_delay_reg   <= cfg_data;
                    CFG_CLEAR_DELAY: clear_delay_reg <= cfg_data;
                    default:         std_delay_reg   <= std_delay_reg;
                endcase
            end
            if (cmd.emit && cmd.load) begin
                held_rs_reg     <= new_rs;
                held_nibble_reg <= new_nib;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item latch and output payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_byte_reg <= s_tdata[7:0];
            item_hold_reg <= s_tdata[23:8];
            item_rs_reg   <= s_tuser[1];
        end
        if (cmd.emit) begin
            m_data_reg <= {2'b00, hold, out_nib, out_rs, cmd.enable};
            m_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: src/char_lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// 4-bit character LCD bus sequencer: turns byte writes and power-up requests
// into timed pin-state phases.
//
//  channel | dir | handshake              | word
//  s_      | in  | s_tvalid / s_tready    | tdata: data_byte, hold_us; tuser: op, reg_select
//  m_      | out | m_tvalid / m_tready    | tdata: enable, rs, data pins, hold; tlast
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (16-bit delay)
//
// One phase word leaves per cycle while m_tready does not stall: a byte write
// is 6 phase words, a power-up run 39. The sequencer takes each item while idle
// and walks one phase per cycle through a single output register.
// Stalls on m_tready hold the sequencer; a new item is taken once the last
// phase is in the output register. Reset is synchronous, active low, and
// restores the delay registers (50 us, 1700 us) and clears the held pins.
// Config is always ready.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // op [0], reg_select [1]
    input  logic [lcdnws_pkg::S_TUSER_W-1:0]      s_tuser,
    // data_byte [7:0], hold_us [23:8]
    input  logic [lcdnws_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // enable_pin [0], rs_pin [1], data_pins [5:2], hold_time_us [21:6], zero [23:22]
    output logic [lcdnws_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  lcdnws_pkg::cfg_index_t                cfg_index,
    input  logic [lcdnws_pkg::HOLD_W-1:0]         cfg_data
);
    import lcdnws_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    op_t        in_op;

    assign cfg_ready = 1'b1;
    assign in_op     = op_t'(s_tuser[0]);

    lcdnws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (in_op),
        .status   (status),
        .cmd      (cmd)
    );

    lcdnws_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // An accepted item keeps the input closed in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a run is starting");

    // A phase is issued only into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("phase issued over a waiting word");

    // The enable strobe is never the closing phase of a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tlast)
        else $error("run ends with enable high");

endmodule

// File: bench/tb_char_lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_write_sequencer
// Self-checking bench for the 4-bit character LCD write sequencer. Byte writes
// and power-up requests go in on the slave stream. A local model of the held
// pins and the delay registers predicts every pin-state phase. Each phase word
// on the master stream is checked field by field against the oldest pending
// prediction. Both streams see random gaps and stalls, and the delay
// registers are rewritten between chunks of traffic.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_write_sequencer;
    import lcdnws_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    // Power-up timing and command bytes, as the display expects them
    localparam logic [15:0] POWER_WAIT_US  = 16'd15000;
    localparam logic [15:0] SECOND_WAIT_US = 16'd4500;
    localparam logic [15:0] THIRD_WAIT_US  = 16'd100;
    localparam logic [3:0]  WAKE_NIBBLE    = 4'h3;
    localparam logic [7:0]  FOUR_BIT_CMD   = 8'h32;
    localparam logic [7:0]  FUNC_SET_CMD   = 8'h28;
    localparam logic [7:0]  DISP_OFF_CMD   = 8'h08;
    localparam logic [7:0]  CLEAR_CMD      = 8'h01;
    localparam logic [7:0]  ENTRY_MODE_CMD = 8'h06;

    // One pin-state phase
    typedef struct packed {
        logic        en;
        logic        rs;
        logic [3:0]  nib;
        logic [15:0] hold;
        logic        last;
    } phase_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_STD_DELAY;
    logic [HOLD_W-1:0]     cfg_data  = '0;

    // Model state: pins now driven and the delay registers
    logic        pins_rs;
    logic [3:0]  pins_nib;
    logic [15:0] std_delay;
    logic [15:0] clear_delay;

    phase_t expected_phases[$];
    int     err_count  = 0;
    int     idle_count = 0;
    bit     calm       = 1'b0;   // no gaps or stalls while set
    int     stall_left = 0;

    char_lcd_nibble_write_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),     // op [0], reg_select [1]
        .s_tdata   (s_tdata),     // data_byte [7:0], hold_us [23:8]
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),     // enable [0], rs [1], data pins [5:2], hold [21:6]
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Phase prediction
    // ------------------------------------------------------------------
    function automatic void queue_phase(logic en, logic [15:0] hold);
        phase_t p;
        p.en   = en;
        p.rs   = pins_rs;
        p.nib  = pins_nib;
        p.hold = hold;
        p.last = 1'b0;
        expected_phases.push_back(p);
    endfunction

    // Enable low on the old pins, high on the new nibble, then low again
    function automatic void queue_nibble(logic [3:0] nib, logic rs, logic [15:0] hold);
        queue_phase(1'b0, hold);
        pins_rs  = rs;
        pins_nib = nib;
        queue_phase(1'b1, hold);
        queue_phase(1'b0, hold);
    endfunction

    function automatic void queue_byte(logic [7:0] b, logic rs, logic [15:0] hold);
        queue_nibble(b[7:4], rs, hold);
        queue_nibble(b[3:0], rs, hold);
    endfunction

    function automatic void predict_phases(op_t op, logic [7:0] b, logic rs,
                                           logic [15:0] hold);
        phase_t tail;
        if (op == OP_WRITE) begin
            queue_byte(b, rs, hold);
        end else begin
            queue_phase(1'b0, POWER_WAIT_US);
            queue_nibble(WAKE_NIBBLE, 1'b0, std_delay);
            queue_phase(1'b0, SECOND_WAIT_US);
            queue_nibble(WAKE_NIBBLE, 1'b0, std_delay);
            queue_phase(1'b0, THIRD_WAIT_US);
            queue_byte(FOUR_BIT_CMD, 1'b0, std_delay);
            queue_byte(FUNC_SET_CMD, 1'b0, std_delay);
            queue_byte(DISP_OFF_CMD, 1'b0, std_delay);
            queue_byte(CLEAR_CMD, 1'b0, clear_delay);
            queue_byte(ENTRY_MODE_CMD, 1'b0, std_delay);
        end
        tail = expected_phases.pop_back();
        tail.last = 1'b1;
        expected_phases.push_back(tail);
    endfunction

    // ------------------------------------------------------------------
    // Output checking
    // ------------------------------------------------------------------
    function automatic void report_field(string name, int unsigned exp_v, int unsigned got_v);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
        err_count++;
    endfunction

    always @(posedge aclk) begin
        phase_t exp_p;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_phases.size() == 0) begin
                $display("%0t: unexpected phase word: expected none, actual %h last=%0b",
                         $time, m_tdata, m_tlast);
                err_count++;
            end else begin
                exp_p = expected_phases.pop_front();
                if (m_tdata[0] !== exp_p.en)
                    report_field("enable_pin", exp_p.en, m_tdata[0]);
                if (m_tdata[1] !== exp_p.rs)
                    report_field("rs_pin", exp_p.rs, m_tdata[1]);
                if (m_tdata[5:2] !== exp_p.nib)
                    report_field("data_pins", exp_p.nib, m_tdata[5:2]);
                if (m_tdata[21:6] !== exp_p.hold)
                    report_field("hold_time_us", exp_p.hold, m_tdata[21:6]);
                if (m_tdata[23:22] !== 2'b00)
                    report_field("tdata padding", 0, m_tdata[23:22]);
                if (m_tlast !== exp_p.last)
                    report_field("last", exp_p.last, m_tlast);
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no handshake at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog timeout, %0d phases pending", $time,
                     expected_phases.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sink side: random stalls on m_tready
    // ------------------------------------------------------------------
    initial begin
        int r;
        forever begin
            @(negedge aclk);
            if (!calm && stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left  = stall_left - 1;
            end else begin
                m_tready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 15)
                    stall_left = $urandom_range(1, 3);
                else if (r < 17)
                    stall_left = $urandom_range(15, 40);
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    // Offer one word and predict its phases once it is taken
    task automatic send_item(op_t op, logic [7:0] b, logic rs, logic [15:0] hold);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= {rs, op};
        s_tdata  <= {hold, b};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_phases(op, b, rs, hold);
    endtask

    // Stop sending and wait until every predicted phase has come out
    task automatic wait_all_phases();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_phases.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_STD_DELAY)
            std_delay = value;
        else
            clear_delay = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_write(logic [7:0] b, logic rs, logic [15:0] hold);
        send_item(OP_WRITE, b, rs, hold);
    endtask

    // Init ignores the other fields; fill them with noise anyway
    task automatic send_init();
        send_item(OP_INIT, 8'($urandom), 1'($urandom), 16'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and alternating patterns; first phase shows reset pins
    task automatic test_byte_writes();
        send_write(8'h00, 1'b0, 16'h0000);
        send_write(8'hFF, 1'b1, 16'hFFFF);
        send_write(8'hA5, 1'b0, 16'h5A5A);
        send_write(8'h5A, 1'b1, 16'hA5A5);
        send_write(8'h0F, 1'b1, 16'h0001);
        send_write(8'hF0, 1'b0, 16'h8000);
        wait_all_phases();
    endtask

    // Power-up with reset delays, from nonzero held pins, then a write after
    task automatic test_power_up();
        send_write(8'hC7, 1'b1, 16'd37);
        send_init();
        send_write(8'h9E, 1'b1, 16'd1234);
        send_init();
        wait_all_phases();
    endtask

    // Delay registers at both ends of their range
    task automatic test_delay_extremes();
        write_reg(CFG_STD_DELAY, 16'h0000);
        write_reg(CFG_CLEAR_DELAY, 16'hFFFF);
        send_init();
        send_write(8'h3C, 1'b0, 16'd7);
        wait_all_phases();
        write_reg(CFG_STD_DELAY, 16'hFFFF);
        write_reg(CFG_CLEAR_DELAY, 16'h0000);
        send_init();
        send_write(8'hE1, 1'b1, 16'hFFFE);
        wait_all_phases();
    endtask

    // Random traffic in chunks, registers rewritten between chunks
    task automatic test_random_traffic();
        int r;
        for (int chunk = 0; chunk < 10; chunk++) begin
            wait_all_phases();
            r = $urandom_range(0, 3);
            write_reg(CFG_STD_DELAY, (r == 0) ? 16'h0000 :
                                     (r == 1) ? 16'hFFFF : 16'($urandom));
            write_reg(CFG_CLEAR_DELAY, 16'($urandom));
            calm = (chunk % 4 == 3);
            for (int n = 0; n < 15; n++) begin
                if ($urandom_range(0, 99) < 6)
                    send_init();
                else
                    send_write(8'($urandom), 1'($urandom), 16'($urandom));
                // now and then hold off until the output has drained
                if ($urandom_range(0, 99) < 3)
                    wait_all_phases();
            end
            calm = 1'b0;
        end
        wait_all_phases();
    endtask

    initial begin
        pins_rs     = 1'b0;
        pins_nib    = 4'h0;
        std_delay   = 16'd50;
        clear_delay = 16'd1700;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_byte_writes();
        test_power_up();
        test_delay_extremes();
        test_random_traffic();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0 && expected_phases.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
